// ===== src/icosphere_face_subdivider_defines.svh =====
// Assertion helpers shared by the RTL.
`ifndef ICOSPHERE_FACE_SUBDIVIDER_DEFINES_SVH
`define ICOSPHERE_FACE_SUBDIVIDER_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define ICS_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define ICS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ics_pkg.sv =====
`default_nettype none
package ics_pkg;
    localparam int MaxVertices = 4096;
    localparam int MaxFaces    = 1024;
    localparam int VCapInt     = ((MaxVertices < 4096) ? MaxVertices : 4096) - 1;
    localparam logic [12:0] VCap = 13'(VCapInt);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_SQ,
        ST_SQRT,
        ST_DIV,
        ST_STORE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic       load;      // capture item
        logic [1:0] edge_sel;  // which midpoint
        logic       sum;       // form sums and squares setup
        logic       sq_step;   // accumulate one square
        logic       sqrt_start;
        logic       sqrt_step;
        logic       div_start;
        logic       div_step;
        logic       store;     // keep normalized vector
    } cmd_t;

    typedef struct packed {
        logic sq_done;
        logic sqrt_done;
        logic div_done;
    } sts_t;
endpackage
`default_nettype wire

// ===== src/icosphere_face_subdivider.sv =====
// Icosphere face subdivider.
// s_ channel: one request per triangle; s_tdata carries nine Q1.14 corner
// coordinates and three corner indices. m_ channel: four faces per request,
// (a,ab,ca), (b,bc,ab), (c,ca,bc), (ab,bc,ca); the first three also carry
// one normalized midpoint. m_tlast marks the fourth face.
// APB registers: 0x0 start_vertex_count (reloads the vertex counter),
// 0x4 face_total.
// Each midpoint steps through the sum, square, root (18 result bits),
// divide and store states in that order; after the third midpoint the four
// faces leave at one per cycle while m_tready is high.
// One triangle is in flight: s_tready stays low until the fourth face is
// taken.
// Reset restores start_vertex_count 12, face_total 20 and clears the pass.
// A stalled m_tready holds the current face; nothing is lost.
`default_nettype none
`include "icosphere_face_subdivider_defines.svh"
module icosphere_face_subdivider (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // a_x,a_y,a_z,b_x,b_y,b_z,c_x,c_y,c_z,corner_a_in,corner_b_in,corner_c_in
    input  wire logic [183:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // out_corner_a,out_corner_b,out_corner_c,new_vertex_valid,new_vertex_index,
    // new_x,new_y,new_z,index_overflow,pass_done
    output logic [103:0]      m_tdata,
    output logic              m_tlast,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    localparam logic [2:0] AddrStart = 3'd0;
    localparam logic [2:0] AddrTotal = 3'd4;

    ics_pkg::cmd_t cmd;
    ics_pkg::sts_t sts;
    logic busy, emit_go, emit_done;
    logic [15:0] mid_reg [3][3];

    logic [11:0] start_reg;
    logic [10:0] total_reg;
    logic [12:0] next_vertex_reg;
    logic [10:0] faces_done_reg;
    logic [11:0] ia_reg, ib_reg, ic_reg;
    logic [11:0] idx_reg [3];
    logic        ovf_reg, done_reg;
    logic [1:0]  r_reg;

    logic wr;
    logic [10:0] tot_eff;
    logic [12:0] v [3];
    logic [13:0] nv;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;
    always_comb begin
        case (paddr)
            AddrStart: prdata = {20'd0, start_reg};
            AddrTotal: prdata = {21'd0, total_reg};
            default:   prdata = '0;
        endcase
    end

    assign s_tready = !busy;

    ics_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .item_req(s_tvalid), .sts(sts),
        .emit_done(emit_done), .cmd(cmd), .busy(busy), .emit_go(emit_go)
    );
    ics_datapath u_dp (
        .aclk(aclk), .cmd(cmd), .sts(sts),
        .item(s_tdata[179:0]), .mid_reg(mid_reg)
    );

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            v[k] = next_vertex_reg + 13'(k);
            if (v[k] > ics_pkg::VCap) v[k] = ics_pkg::VCap;
        end
        nv = 14'(next_vertex_reg) + 14'd3;
        if (nv > 14'(ics_pkg::VCap) + 14'd1) nv = 14'(ics_pkg::VCap) + 14'd1;
        tot_eff = (total_reg == 11'd0) ? 11'd1 :
                  (total_reg > 11'(ics_pkg::MaxFaces)) ? 11'(ics_pkg::MaxFaces) : total_reg;
    end

    assign m_tvalid  = emit_go;
    assign emit_done = emit_go && m_tready && (r_reg == 2'd3);
    assign m_tlast   = (r_reg == 2'd3);

    always_comb begin
        logic [11:0] oa, ob, oc;
        logic [15:0] nx, ny, nz;
        logic [11:0] ni;
        oa = idx_reg[0]; ob = idx_reg[1]; oc = idx_reg[2];
        nx = '0; ny = '0; nz = '0; ni = '0;
        case (r_reg)
            2'd0: begin oa = ia_reg; ob = idx_reg[0]; oc = idx_reg[2]; end
            2'd1: begin oa = ib_reg; ob = idx_reg[1]; oc = idx_reg[0]; end
            2'd2: begin oa = ic_reg; ob = idx_reg[2]; oc = idx_reg[1]; end
            default: ;
        endcase
        if (r_reg != 2'd3) begin
            ni = idx_reg[r_reg];
            nx = mid_reg[r_reg][0]; ny = mid_reg[r_reg][1]; nz = mid_reg[r_reg][2];
        end
        m_tdata = {5'd0, (r_reg == 2'd3) && done_reg, ovf_reg, nz, ny, nx, ni,
                   (r_reg != 2'd3), oc, ob, oa};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg       <= 12'd12;
            total_reg       <= 11'd20;
            next_vertex_reg <= 13'd12;
            faces_done_reg  <= '0;
            r_reg           <= '0;
        end else begin
            if (cmd.load) begin
                ia_reg <= s_tdata[155:144];
                ib_reg <= s_tdata[167:156];
                ic_reg <= s_tdata[179:168];
                for (int k = 0; k < 3; k++) idx_reg[k] <= v[k][11:0];
                ovf_reg  <= (next_vertex_reg + 13'd2) > ics_pkg::VCap;
                done_reg <= (faces_done_reg + 11'd1) >= tot_eff;
                if ((faces_done_reg + 11'd1) >= tot_eff) begin
                    faces_done_reg  <= '0;
                    next_vertex_reg <= {1'b0, start_reg};
                end else begin
                    faces_done_reg  <= faces_done_reg + 11'd1;
                    next_vertex_reg <= nv[12:0];
                end
                r_reg <= '0;
            end
            if (emit_go && m_tready) r_reg <= r_reg + 2'd1;
            if (wr && paddr == AddrStart) begin
                start_reg       <= pwdata[11:0];
                next_vertex_reg <= {1'b0, pwdata[11:0]};
            end
            if (wr && paddr == AddrTotal) total_reg <= pwdata[10:0];
        end
    end

    `ICS_ASSERT_IMP(a_no_accept_busy, aclk, aresetn, busy, !s_tready, "accept while busy")
    `ICS_ASSERT_IMP(a_last_done, aclk, aresetn, m_tvalid && m_tdata[98], m_tlast,
                    "pass_done off last")
    `ICS_ASSERT_NEXT(a_vcount, aclk, aresetn, 1'b1,
                     next_vertex_reg <= ics_pkg::VCap + 13'd1, "vertex counter past cap")
endmodule
`default_nettype wire

// ===== src/ics_ctrl.sv =====
`default_nettype none
module ics_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          item_req,
    input  wire ics_pkg::sts_t sts,
    input  wire logic          emit_done,
    output ics_pkg::cmd_t      cmd,
    output logic               busy,
    output logic               emit_go
);
    ics_pkg::state_t state_reg, state_next;
    logic [1:0] edge_reg, edge_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ics_pkg::ST_IDLE;
            edge_reg  <= 2'd0;
        end else begin
            state_reg <= state_next;
            edge_reg  <= edge_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        edge_next  = edge_reg;
        cmd        = '0;
        cmd.edge_sel = edge_reg;
        busy       = 1'b1;
        emit_go    = 1'b0;
        case (state_reg)
            ics_pkg::ST_IDLE: begin
                busy = 1'b0;
                if (item_req) begin
                    cmd.load   = 1'b1;
                    edge_next  = 2'd0;
                    state_next = ics_pkg::ST_SUM;
                end
            end
            ics_pkg::ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ics_pkg::ST_SQ;
            end
            ics_pkg::ST_SQ: begin
                // the last square is added by the root setup
                if (sts.sq_done) begin
                    cmd.sqrt_start = 1'b1;
                    state_next = ics_pkg::ST_SQRT;
                end else begin
                    cmd.sq_step = 1'b1;
                end
            end
            ics_pkg::ST_SQRT: begin
                if (sts.sqrt_done) begin
                    cmd.div_start = 1'b1;
                    state_next = ics_pkg::ST_DIV;
                end else begin
                    cmd.sqrt_step = 1'b1;
                end
            end
            ics_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_done) state_next = ics_pkg::ST_STORE;
            end
            ics_pkg::ST_STORE: begin
                cmd.store = 1'b1;
                if (edge_reg == 2'd2) begin
                    state_next = ics_pkg::ST_EMIT;
                end else begin
                    edge_next  = edge_reg + 2'd1;
                    state_next = ics_pkg::ST_SUM;
                end
            end
            ics_pkg::ST_EMIT: begin
                emit_go = 1'b1;
                if (emit_done) state_next = ics_pkg::ST_IDLE;
            end
            default: state_next = ics_pkg::ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ===== src/ics_datapath.sv =====
`default_nettype none
module ics_datapath (
    input  wire logic          aclk,
    input  wire ics_pkg::cmd_t cmd,
    output ics_pkg::sts_t      sts,
    input  wire logic [179:0]  item,
    output logic [15:0]        mid_reg [3][3]
);
    logic signed [15:0] crd_reg [9];
    logic signed [16:0] s_reg [3];
    logic [1:0]  k_reg;
    logic [35:0] l2_reg;
    // square root: digit-by-digit, one result bit per cycle
    logic [35:0] rem_reg;
    logic [17:0] root_reg;
    logic [4:0]  sq_cnt_reg;
    // divider: restoring, one quotient bit per cycle, three components
    logic [32:0] num_reg [3];
    logic [32:0] dr_reg [3];
    logic [14:0] q_reg [3];
    logic [4:0]  dv_cnt_reg;

    logic [1:0]  pi, qi;
    logic signed [16:0] sk;
    logic [33:0] sqv;
    logic [37:0] trial;
    logic [35:0] rem_sh;
    logic [16:0] mag [3];

    always_comb begin
        case (cmd.edge_sel)
            2'd0: begin pi = 2'd0; qi = 2'd1; end
            2'd1: begin pi = 2'd1; qi = 2'd2; end
            default: begin pi = 2'd2; qi = 2'd0; end
        endcase
        sk     = s_reg[k_reg];
        sqv    = 34'(sk * sk);
        rem_sh = {rem_reg[33:0], l2_reg[35:34]};
        trial  = {2'b0, rem_sh} - {18'b0, root_reg, 2'b01};
        for (int j = 0; j < 3; j++)
            mag[j] = s_reg[j][16] ? 17'(-s_reg[j]) : 17'(s_reg[j]);
    end

    assign sts.sq_done   = (k_reg == 2'd2);
    assign sts.sqrt_done = (sq_cnt_reg == 5'd18);
    assign sts.div_done  = (dv_cnt_reg == 5'd14);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            for (int i = 0; i < 9; i++) crd_reg[i] <= item[16*i +: 16];
        end
        if (cmd.sum) begin
            for (int j = 0; j < 3; j++)
                s_reg[j] <= 17'(crd_reg[3*pi + j]) + 17'(crd_reg[3*qi + j]);
            k_reg  <= 2'd0;
            l2_reg <= '0;
        end
        if (cmd.sq_step) begin
            l2_reg <= l2_reg + 36'(sqv);
            k_reg  <= k_reg + 2'd1;
        end
        if (cmd.sqrt_start) begin
            rem_reg    <= '0;
            root_reg   <= '0;
            sq_cnt_reg <= '0;
            l2_reg     <= l2_reg + 36'(sqv);
        end
        if (cmd.sqrt_step) begin
            l2_reg     <= {l2_reg[33:0], 2'b00};
            sq_cnt_reg <= sq_cnt_reg + 5'd1;
            if (!trial[37]) begin
                rem_reg  <= trial[35:0];
                root_reg <= {root_reg[16:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[16:0], 1'b0};
            end
        end
        if (cmd.div_start) begin
            dv_cnt_reg <= '0;
            for (int j = 0; j < 3; j++) begin
                // (|s|*32768 + len) / (2*len), quotient below 2^15
                num_reg[j] <= {1'b0, mag[j], 15'b0} + 33'(root_reg);
                dr_reg[j]  <= {root_reg, 15'b0};
                q_reg[j]   <= '0;
            end
        end
        if (cmd.div_step) begin
            dv_cnt_reg <= dv_cnt_reg + 5'd1;
            for (int j = 0; j < 3; j++) begin
                dr_reg[j] <= dr_reg[j] >> 1;
                if (num_reg[j] >= dr_reg[j]) begin
                    num_reg[j] <= num_reg[j] - dr_reg[j];
                    q_reg[j]   <= {q_reg[j][13:0], 1'b1};
                end else begin
                    q_reg[j]   <= {q_reg[j][13:0], 1'b0};
                end
            end
        end
        if (cmd.store) begin
            for (int j = 0; j < 3; j++) begin
                if (root_reg == 18'd0)
                    mid_reg[cmd.edge_sel][j] <= '0;
                else if (s_reg[j][16])
                    mid_reg[cmd.edge_sel][j] <= 16'(-{1'b0, q_reg[j]});
                else
                    mid_reg[cmd.edge_sel][j] <= {1'b0, q_reg[j]};
            end
        end
    end
endmodule
`default_nettype wire
